// ===== sv/lruc_pkg.sv =====
package lruc_pkg;

    // Number of cache slots.
    localparam int ENTRIES = 16;

    // Slot index / recency rank width, occupancy count width.
    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W = $clog2(ENTRIES + 1);

    // Field widths fixed by the interface.
    localparam int KEY_W = 32;
    localparam int VAL_W = 32;
    localparam int CAP_W = 5;

    // Width used when comparing occupancy against capacity.
    localparam int CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;

    // APB register map.
    localparam int          ADDR_W        = 3;
    localparam int          DATA_W        = 32;
    localparam logic [ADDR_W-1:0] ADDR_CAPACITY = ADDR_W'(0);

    localparam logic [CAP_W-1:0] CAP_RESET  = CAP_W'(16);
    localparam logic [VAL_W-1:0] MISS_VALUE = '1;

    localparam logic REQ_GET = 1'b0;
    localparam logic REQ_SET = 1'b1;

    // Write port of the key/value store.
    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] addr;
        logic [KEY_W-1:0] key;
        logic [VAL_W-1:0] value;
    } t_mem_wr;

endpackage

// ===== sv/lru_key_value_cache.sv =====
// Channel   Direction  Handshake                    Payload
// request   in         i_req_valid / o_req_ready    i_req_type, i_lookup_key, i_write_value
// response  out        o_rsp_valid / i_rsp_ready    o_found, o_read_value, o_evicted
// config    in         APB psel/penable/pwrite      paddr, pwdata -> prdata (capacity)
//
// A request is taken in idle, then the sequencer walks all slots through the single
// key comparator (one slot per cycle out of the key/value RAM), drains the RAM read
// pipeline, and finally commits and loads the response.
// Reset (synchronous, active low) clears valid bits, ranks and occupancy at once and
// sets capacity to 16; key and value RAM contents are left as they are.
// A stalled response holds the commit step; a new request is taken as soon as the
// sequencer is back in idle, even while the previous response waits for its transfer.
module lru_key_value_cache
    import lruc_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,

    input  logic                    i_req_valid,
    output logic                    o_req_ready,
    input  logic                    i_req_type,
    input  logic signed [KEY_W-1:0] i_lookup_key,
    input  logic signed [VAL_W-1:0] i_write_value,

    output logic                    o_rsp_valid,
    input  logic                    i_rsp_ready,
    output logic                    o_found,
    output logic signed [VAL_W-1:0] o_read_value,
    output logic                    o_evicted,

    input  logic                    psel,
    input  logic                    penable,
    input  logic                    pwrite,
    input  logic [ADDR_W-1:0]       paddr,
    input  logic [DATA_W-1:0]       pwdata,
    output logic [DATA_W-1:0]       prdata,
    output logic                    pready
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_FINISH
    } t_state;

    t_state r_state;

    // Sequencer and scan bookkeeping
    logic [IDX_W-1:0] r_idx;       // slot address presented to the RAM
    logic             r_chk_vld;   // RAM output belongs to a slot under compare
    logic [IDX_W-1:0] r_chk_idx;   // slot whose key/value is on the RAM output
    logic             r_hit;
    logic [IDX_W-1:0] r_hit_idx;
    logic             r_lru_any;
    logic [IDX_W-1:0] r_lru_idx;
    logic [IDX_W-1:0] r_lru_rank;
    logic             r_free_any;
    logic [IDX_W-1:0] r_free_idx;

    // Per-slot state
    logic [ENTRIES-1:0] r_valid;
    logic [IDX_W-1:0]   r_rank [ENTRIES];
    logic [CNT_W-1:0]   r_occ;
    logic [CAP_W-1:0]   r_cap;

    // Response register
    logic             r_rsp_valid;
    logic             r_found;
    logic [VAL_W-1:0] r_read_value;
    logic             r_evicted;

    // Latched request payload
    logic             r_type;
    logic [KEY_W-1:0] r_key;
    logic [VAL_W-1:0] r_val;
    logic [VAL_W-1:0] r_hit_val;

    // RAM interface
    t_mem_wr          mem_wr;
    logic [KEY_W-1:0] rd_key;
    logic [VAL_W-1:0] rd_value;

    lruc_kv_mem u_mem (
        .i_clk      (i_clk),
        .i_wr       (mem_wr),
        .i_rd_addr  (r_idx),
        .o_rd_key   (rd_key),
        .o_rd_value (rd_value)
    );

    // ------------------------------------------------------------------
    // Handshakes and configuration decode
    // ------------------------------------------------------------------
    logic req_xfer;
    logic cfg_wr;
    logic commit;

    assign req_xfer = i_req_valid && (r_state == S_IDLE);
    assign cfg_wr   = psel && penable && pwrite && (paddr == ADDR_CAPACITY);
    // Commit only when the response register is free or being drained this cycle.
    assign commit   = (r_state == S_FINISH) && (!r_rsp_valid || i_rsp_ready);

    // ------------------------------------------------------------------
    // Compare stage: one slot per cycle on the registered RAM output
    // ------------------------------------------------------------------
    logic chk_slot_valid;
    logic chk_match;
    logic chk_older;

    assign chk_slot_valid = r_chk_vld && r_valid[r_chk_idx];
    assign chk_match      = chk_slot_valid && (rd_key == r_key);
    // First valid slot seeds the search, then only a strictly older rank wins.
    assign chk_older      = chk_slot_valid && (!r_lru_any || (r_rank[r_chk_idx] > r_lru_rank));

    // ------------------------------------------------------------------
    // Decision: target slot, eviction, recency update
    // ------------------------------------------------------------------
    logic [CMP_W-1:0] eff_cap;
    logic             full;
    logic             do_evict;
    logic             do_insert;
    logic [IDX_W-1:0] target;
    logic [IDX_W-1:0] limit;
    logic             use_limit;
    logic [IDX_W-1:0] n_rank [ENTRIES];

    always_comb begin
        // Zero capacity acts as one, anything above the slot count saturates.
        if (r_cap == '0) begin
            eff_cap = CMP_W'(1);
        end else if (CMP_W'(r_cap) > CMP_W'(ENTRIES)) begin
            eff_cap = CMP_W'(ENTRIES);
        end else begin
            eff_cap = CMP_W'(r_cap);
        end
    end

    assign full      = (CMP_W'(r_occ) >= eff_cap) && (r_occ != '0);
    assign do_insert = !r_hit && (r_type == REQ_SET);
    assign do_evict  = do_insert && full && r_lru_any;
    assign target    = r_hit ? r_hit_idx : (do_evict ? r_lru_idx : r_free_idx);
    // A hit ages only the slots more recent than it; an insert ages every other valid slot.
    assign limit     = r_rank[r_hit_idx];
    assign use_limit = r_hit;

    always_comb begin
        for (int i = 0; i < ENTRIES; i++) begin
            n_rank[i] = r_rank[i];
            if (IDX_W'(i) == target) begin
                n_rank[i] = '0;
            end else if (r_valid[i] && (!use_limit || (r_rank[i] < limit))) begin
                n_rank[i] = r_rank[i] + IDX_W'(1);
            end
        end
    end

    always_comb begin
        mem_wr.en    = commit && (r_type == REQ_SET);
        mem_wr.addr  = target;
        mem_wr.key   = r_key;
        mem_wr.value = r_val;
    end

    // ------------------------------------------------------------------
    // Sequencer, per-slot state and response register
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_idx        <= '0;
            r_chk_vld    <= 1'b0;
            r_chk_idx    <= '0;
            r_hit        <= 1'b0;
            r_hit_idx    <= '0;
            r_lru_any    <= 1'b0;
            r_lru_idx    <= '0;
            r_lru_rank   <= '0;
            r_free_any   <= 1'b0;
            r_free_idx   <= '0;
            r_valid      <= '0;
            for (int i = 0; i < ENTRIES; i++) begin
                r_rank[i] <= '0;
            end
            r_occ        <= '0;
            r_cap        <= CAP_RESET;
            r_rsp_valid  <= 1'b0;
            r_found      <= 1'b0;
            r_read_value <= '0;
            r_evicted    <= 1'b0;
        end else begin
            if (cfg_wr) begin
                r_cap <= pwdata[CAP_W-1:0];
            end

            // Drop valid after the transfer unless a new response loads this cycle.
            if (r_rsp_valid && i_rsp_ready && !commit) begin
                r_rsp_valid <= 1'b0;
            end

            // Track the RAM read pipeline.
            r_chk_vld <= (r_state == S_SCAN);
            r_chk_idx <= r_idx;

            if (r_chk_vld) begin
                if (chk_match && !r_hit) begin
                    r_hit     <= 1'b1;
                    r_hit_idx <= r_chk_idx;
                end
                if (chk_older) begin
                    r_lru_any  <= 1'b1;
                    r_lru_idx  <= r_chk_idx;
                    r_lru_rank <= r_rank[r_chk_idx];
                end
                if (!r_valid[r_chk_idx] && !r_free_any) begin
                    r_free_any <= 1'b1;
                    r_free_idx <= r_chk_idx;
                end
            end

            case (r_state)
                S_IDLE: begin
                    if (req_xfer) begin
                        r_idx      <= '0;
                        r_hit      <= 1'b0;
                        r_lru_any  <= 1'b0;
                        r_free_any <= 1'b0;
                        r_state    <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    // Advance the address; the last slot still needs its compare.
                    if (r_idx == IDX_W'(ENTRIES - 1)) begin
                        r_state <= S_DRAIN;
                    end else begin
                        r_idx <= r_idx + IDX_W'(1);
                    end
                end
                S_DRAIN: begin
                    r_state <= S_FINISH;
                end
                S_FINISH: begin
                    if (commit) begin
                        if (r_hit || do_insert) begin
                            r_rank <= n_rank;
                        end
                        if (do_insert) begin
                            r_valid[target] <= 1'b1;
                            if (!do_evict) begin
                                r_occ <= r_occ + CNT_W'(1);
                            end
                        end
                        r_rsp_valid <= 1'b1;
                        r_found     <= r_hit;
                        r_evicted   <= do_evict;
                        if (r_type == REQ_SET) begin
                            r_read_value <= '0;
                        end else if (r_hit) begin
                            r_read_value <= r_hit_val;
                        end else begin
                            r_read_value <= MISS_VALUE;
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // Request payload and captured hit value: no reset needed.
    always_ff @(posedge i_clk) begin
        if (req_xfer) begin
            r_type <= i_req_type;
            r_key  <= i_lookup_key;
            r_val  <= i_write_value;
        end
        if (chk_match && !r_hit) begin
            r_hit_val <= rd_value;
        end
    end

    // ------------------------------------------------------------------
    // Outputs
    // ------------------------------------------------------------------
    assign o_req_ready  = (r_state == S_IDLE);
    assign o_rsp_valid  = r_rsp_valid;
    assign o_found      = r_found;
    assign o_read_value = r_read_value;
    assign o_evicted    = r_evicted;

    assign pready = 1'b1;
    assign prdata = (paddr == ADDR_CAPACITY) ? DATA_W'(r_cap) : '0;

endmodule

// ===== sv/lruc_kv_mem.sv =====
module lruc_kv_mem
    import lruc_pkg::*;
(
    input  logic             i_clk,
    input  t_mem_wr          i_wr,
    input  logic [IDX_W-1:0] i_rd_addr,
    output logic [KEY_W-1:0] o_rd_key,
    output logic [VAL_W-1:0] o_rd_value
);

    logic [KEY_W-1:0] r_key_mem [ENTRIES];
    logic [VAL_W-1:0] r_val_mem [ENTRIES];
    logic [KEY_W-1:0] r_rd_key;
    logic [VAL_W-1:0] r_rd_value;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_key_mem[i_wr.addr] <= i_wr.key;
            r_val_mem[i_wr.addr] <= i_wr.value;
        end
        r_rd_key   <= r_key_mem[i_rd_addr];
        r_rd_value <= r_val_mem[i_rd_addr];
    end

    assign o_rd_key   = r_rd_key;
    assign o_rd_value = r_rd_value;

endmodule
